/* src/base64_stream_encoder_assert.svh */
// Assertion macros shared by the encoder modules.
// The including module must have clk and an active-low reset named rst_n.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF

`define B64_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define B64_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define B64_ASSERT(label, prop, msg)

`define B64_NEVER(label, expr, msg)

`endif

`endif

/* src/b64_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_pkg
// Types, constants and the alphabet lookup for the Base64 stream encoder.
// ---------------------------------------------------------------------------
package b64_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // How many message bytes a group carries.
    typedef enum logic [1:0] {
        GRP_FULL = 2'd0,
        GRP_ONE  = 2'd1,
        GRP_TWO  = 2'd2
    } grp_kind_t;

    // One encoding job handed from the front to the back.
    typedef struct packed {
        logic [23:0] word;
        grp_kind_t   kind;
        logic        last;
        logic        url;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] idx, input logic url);
        logic [5:0] v;
        logic [7:0] ch;
        v = idx & SEXTET_MASK;
        if (v < 6'd26) begin
            ch = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52) begin
            ch = 8'h61 + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62) begin
            ch = 8'h30 + {2'b00, v - 6'd52};
        end
        else if (v == 6'd62) begin
            ch = url ? 8'h2D : 8'h2B;
        end
        else begin
            ch = url ? 8'h5F : 8'h2F;
        end
        return ch;
    endfunction

endpackage

/* src/b64_byte_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_byte_if
// Message byte channel: one raw byte per item with a last-byte mark.
// ---------------------------------------------------------------------------
interface b64_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/b64_char_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_char_if
// Encoded character channel: one ASCII character per item with a last mark.
// ---------------------------------------------------------------------------
interface b64_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

/* src/b64_cfg_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_cfg_if
// Configuration write channel carrying the url_safe register value.
// ---------------------------------------------------------------------------
interface b64_cfg_if;
    logic valid;
    logic ready;
    logic url_safe;

    modport source (output valid, output url_safe, input ready);
    modport sink   (input valid, input url_safe, output ready);
endinterface

/* src/b64_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_queue
// Small job queue that decouples the byte front from the character back.
// ---------------------------------------------------------------------------
module b64_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  b64_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output b64_pkg::job_t pop_data
);
    import b64_pkg::*;
`include "base64_stream_encoder_assert.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `B64_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "job queue count exceeds depth")
    `B64_ASSERT(a_count_track, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "job queue count lost a push")

endmodule

/* src/b64_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_front
// Accepts message bytes, gathers three-byte groups and issues encoding jobs.
// ---------------------------------------------------------------------------
module b64_front (
    input  logic          clk,
    input  logic          rst_n,
    b64_byte_if.sink      msg,
    b64_cfg_if.sink       cfg,
    output logic          job_valid,
    input  logic          job_ready,
    output b64_pkg::job_t job
);
    import b64_pkg::*;
`include "base64_stream_encoder_assert.svh"

    logic [15:0] held_reg, held_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        url_reg;
    logic        accept;

    assign msg.ready = job_ready;
    assign cfg.ready = 1'b1;
    assign accept    = msg.valid && msg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            url_reg <= cfg.url_safe;
        end
    end

    // A full group or any last byte produces a job; otherwise the byte is held.
    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        job_valid = 1'b0;
        job.word  = {held_reg, msg.data_byte};
        job.kind  = GRP_FULL;
        job.last  = msg.last_byte;
        job.url   = url_reg;
        case (cnt_reg)
            2'd2:
            begin
                job_valid = accept;
                if (accept)
                begin
                    cnt_next = 2'd0;
                end
            end
            2'd1:
            begin
                job.word = {held_reg[15:8], msg.data_byte, 8'h00};
                job.kind = GRP_TWO;
                job_valid = accept && msg.last_byte;
                if (accept)
                begin
                    held_next = {held_reg[15:8], msg.data_byte};
                    cnt_next  = msg.last_byte ? 2'd0 : 2'd2;
                end
            end
            default:
            begin
                job.word = {msg.data_byte, 16'h0000};
                job.kind = GRP_ONE;
                job_valid = accept && msg.last_byte;
                if (accept)
                begin
                    held_next = {msg.data_byte, 8'h00};
                    cnt_next  = msg.last_byte ? 2'd0 : 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
        end
    end

    `B64_NEVER(a_cnt_legal, cnt_reg == 2'd3, "group count reached three")
    `B64_ASSERT(a_last_flushes, (accept && msg.last_byte) |=> (cnt_reg == 2'd0), "last byte left bytes held")

endmodule

/* src/b64_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_back
// Jobs to ASCII characters, one per cycle unless stalled; standard mode pads.
// ---------------------------------------------------------------------------
module b64_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  b64_pkg::job_t job,
    b64_char_if.source    code
);
    import b64_pkg::*;
`include "base64_stream_encoder_assert.svh"

    job_t       work_reg, work_next;
    logic       work_valid_reg, work_valid_next;
    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_last_reg, out_last_next;
    logic [1:0] final_idx;
    logic [2:0] n_sextets;
    logic [5:0] sextet;
    logic       advance;
    logic       at_final;

    assign code.valid     = out_valid_reg;
    assign code.out_char  = out_char_reg;
    assign code.last_char = out_last_reg;

    // Unpadded partial groups stop early in URL-safe mode.
    always_comb
    begin
        case (work_reg.kind)
            GRP_ONE:
            begin
                n_sextets = 3'd2;
                final_idx = work_reg.url ? 2'd1 : 2'd3;
            end
            GRP_TWO:
            begin
                n_sextets = 3'd3;
                final_idx = work_reg.url ? 2'd2 : 2'd3;
            end
            default:
            begin
                n_sextets = 3'd4;
                final_idx = 2'd3;
            end
        endcase
        case (k_reg)
            2'd0:    sextet = work_reg.word[23:18];
            2'd1:    sextet = work_reg.word[17:12];
            2'd2:    sextet = work_reg.word[11:6];
            default: sextet = work_reg.word[5:0];
        endcase
    end

    assign advance   = work_valid_reg && (!out_valid_reg || code.ready);
    assign at_final  = (k_reg == final_idx);
    assign job_ready = !work_valid_reg || (advance && at_final);

    always_comb
    begin
        work_next       = work_reg;
        work_valid_next = work_valid_reg;
        k_next          = k_reg;
        if (job_valid && job_ready)
        begin
            work_next       = job;
            work_valid_next = 1'b1;
            k_next          = 2'd0;
        end
        else if (advance && at_final)
        begin
            work_valid_next = 1'b0;
        end
        else if (advance)
        begin
            k_next = k_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ({1'b0, k_reg} < n_sextets) ? sextet_char(sextet, work_reg.url)
                                                         : PAD_CHAR;
            out_last_next  = at_final && ((work_reg.kind != GRP_FULL) || work_reg.last);
        end
        else if (code.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    `B64_ASSERT(a_index_bound, work_valid_reg |-> (k_reg <= final_idx), "character index past end of group")
    `B64_ASSERT(a_out_source, $rose(out_valid_reg) |-> $past(work_valid_reg), "character issued without a job")

endmodule

/* src/base64_stream_encoder.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder, standard or URL-safe alphabet.
// ---------------------------------------------------------------------------
//  Channel   Dir   Item contents
//  msg       in    data_byte[7:0], last_byte
//  code      out   out_char[7:0], last_char
//  cfg       in    url_safe (register write, always ready)
//
//  Bytes are taken one per cycle while the job queue has room; characters
//  leave one per cycle from a registered output while the receiver is ready;
//  a long message yields four characters per three bytes via the single port.
//  A job crosses the queue slot, the work register and the output register.
//  Reset clears held bytes, the queue and the output; url_safe resets to 0.
//  A stalled output fills the queue, after which msg.ready drops.
// ---------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    b64_byte_if.sink  msg,
    b64_char_if.source code,
    b64_cfg_if.sink   cfg
);
    import b64_pkg::*;

    job_t front_job;
    job_t back_job;
    logic front_valid;
    logic front_ready;
    logic back_valid;
    logic back_ready;

    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .cfg       (cfg),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .code      (code)
    );

endmodule

/* tb/base64_stream_encoder_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_encoder_tb
// Drives byte messages into the encoder and checks every encoded character
// against a local Base64 predictor. The run covers both alphabets, padding,
// partial final groups and random stalls on both channels.
// ---------------------------------------------------------------------------
module base64_stream_encoder_tb;
    import b64_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } code_char_t;

    logic clk;
    logic rst_n;

    b64_byte_if msg_if ();
    b64_char_if code_if ();
    b64_cfg_if  cfg_if ();

    base64_stream_encoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .code  (code_if),
        .cfg   (cfg_if)
    );

    string std_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string url_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    msg_byte_t  pending_bytes[$];
    code_char_t expected_chars[$];

    // Predictor state.
    logic [15:0] held_pair;
    logic [1:0]  held_count;
    logic        url_mode;

    int bytes_sent;
    int bytes_taken;
    int send_idle_pct;
    int recv_idle_pct;
    int stalled_cycles;
    int error_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [7:0] sextet_symbol(input logic [23:0] word, input int shift);
        logic [5:0] idx;
        idx = word[shift +: 6];
        return url_mode ? url_alphabet[idx] : std_alphabet[idx];
    endfunction

    function automatic void push_char(input logic [7:0] ch, input logic last);
        code_char_t c;
        c.ch   = ch;
        c.last = last;
        expected_chars.push_back(c);
    endfunction

    // Updates the held group with one accepted byte and queues the characters it releases.
    function automatic void predict_chars(input logic [7:0] data, input logic last);
        logic [23:0] word;
        if (held_count == 2'd2)
        begin
            word = {held_pair, data};
            push_char(sextet_symbol(word, 18), 1'b0);
            push_char(sextet_symbol(word, 12), 1'b0);
            push_char(sextet_symbol(word, 6), 1'b0);
            push_char(sextet_symbol(word, 0), last);
            held_pair  = '0;
            held_count = 2'd0;
        end
        else if (!last)
        begin
            if (held_count == 2'd0)
                held_pair = {data, 8'h00};
            else
                held_pair[7:0] = data;
            held_count = held_count + 2'd1;
        end
        else
        begin
            if (held_count == 2'd0)
            begin
                word = {data, 16'h0000};
                push_char(sextet_symbol(word, 18), 1'b0);
                push_char(sextet_symbol(word, 12), url_mode);
                if (!url_mode)
                begin
                    push_char(PAD_CHAR, 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                end
            end
            else
            begin
                word = {held_pair[15:8], data, 8'h00};
                push_char(sextet_symbol(word, 18), 1'b0);
                push_char(sextet_symbol(word, 12), 1'b0);
                push_char(sextet_symbol(word, 6), url_mode);
                if (!url_mode)
                    push_char(PAD_CHAR, 1'b1);
            end
            held_pair  = '0;
            held_count = 2'd0;
        end
    endfunction

    task automatic queue_byte(input logic [7:0] data, input logic last);
        msg_byte_t b;
        b.data = data;
        b.last = last;
        pending_bytes.push_back(b);
    endtask

    // Mostly short messages, now and then a long one; the final byte always closes a message.
    task automatic queue_random_messages(input int byte_total);
        int remaining;
        int len;
        remaining = byte_total;
        while (remaining > 0)
        begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            if (len > remaining)
                len = remaining;
            for (int i = 0; i < len; i++)
                queue_byte(8'($urandom_range(0, 255)), i == len - 1);
            remaining -= len;
        end
    endtask

    task automatic drain_and_settle();
        while (pending_bytes.size() != 0 || bytes_taken != bytes_sent ||
               expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_url_mode(input logic mode);
        @(negedge clk);
        cfg_if.valid    <= 1'b1;
        cfg_if.url_safe <= mode;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Byte driver: presents the next pending item once the previous one was taken.
    always @(negedge clk)
    begin : drive_msg
        msg_byte_t nxt;
        if (rst_n)
        begin
            if (!msg_if.valid || bytes_taken == bytes_sent)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    msg_if.valid     <= 1'b1;
                    msg_if.data_byte <= nxt.data;
                    msg_if.last_byte <= nxt.last;
                    bytes_sent++;
                end
                else
                begin
                    msg_if.valid <= 1'b0;
                end
            end
            code_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watch_channels
        code_char_t want;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                url_mode = cfg_if.url_safe;
            if (msg_if.valid && msg_if.ready)
            begin
                predict_chars(msg_if.data_byte, msg_if.last_byte);
                bytes_taken++;
            end
            if (code_if.valid && code_if.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                              code_if.out_char, code_if.last_char));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (code_if.out_char !== want.ch)
                        report_mismatch($sformatf("out_char 0x%02h, predicted 0x%02h",
                                                  code_if.out_char, want.ch));
                    if (code_if.last_char !== want.last)
                        report_mismatch($sformatf("last_char %0b, predicted %0b on 0x%02h",
                                                  code_if.last_char, want.last, want.ch));
                end
            end
            if ((msg_if.valid && msg_if.ready) || (code_if.valid && code_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles == STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        msg_if.valid     = 1'b0;
        msg_if.data_byte = 8'h00;
        msg_if.last_byte = 1'b0;
        code_if.ready    = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.url_safe  = 1'b0;
        held_pair        = '0;
        held_count       = 2'd0;
        url_mode         = 1'b0;
        bytes_sent       = 0;
        bytes_taken      = 0;
        stalled_cycles   = 0;
        error_count      = 0;
        send_idle_pct    = 34;
        recv_idle_pct    = 82;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Standard alphabet from reset: one-, two- and three-byte groups, the two
        // top symbols, and full groups followed by each kind of partial group.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hBF, 1'b1);
        queue_byte(8'h00, 1'b0); queue_byte(8'h10, 1'b0); queue_byte(8'h83, 1'b0);
        queue_byte(8'h10, 1'b1);
        queue_byte(8'h12, 1'b0); queue_byte(8'h34, 1'b0); queue_byte(8'h56, 1'b0);
        queue_byte(8'h78, 1'b0); queue_byte(8'h9A, 1'b1);
        // This message stays open across the switch to the URL-safe alphabet.
        queue_byte(8'hFB, 1'b0);
        drain_and_settle();

        write_url_mode(1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hBF, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b1);
        drain_and_settle();

        write_url_mode(1'b0);
        queue_random_messages(126);
        drain_and_settle();

        send_idle_pct = 82;
        recv_idle_pct = 34;
        write_url_mode(1'b1);
        queue_random_messages(126);
        drain_and_settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_url_mode(1'($urandom_range(0, 1)));
        queue_random_messages(126);
        drain_and_settle();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
